@@ sv/btop_pkg.sv @@
// ----------------------------------------------------------------------------
// btop_pkg
// Shared types, register codes and helpers for the binomial tree pricer.
// ----------------------------------------------------------------------------
package btop_pkg;

    localparam int CFG_IDX_W = 8;
    localparam int STEPS_W   = 9;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_UP_FACTOR   = 8'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DOWN_FACTOR = 8'd1;
    localparam logic [CFG_IDX_W-1:0] REG_UP_PROB     = 8'd2;
    localparam logic [CFG_IDX_W-1:0] REG_DISCOUNT    = 8'd3;

    // configuration reset values
    localparam logic [31:0] UP_FACTOR_RST   = 32'd1181116006;
    localparam logic [31:0] DOWN_FACTOR_RST = 32'd966367642;
    localparam logic [31:0] UP_PROB_RST     = 32'd1073741824;
    localparam logic [31:0] DISCOUNT_RST    = 32'd2126221434;

    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    typedef struct packed {
        logic [31:0]        spot;
        logic [31:0]        strike;
        logic [STEPS_W-1:0] steps;
        logic               is_put;
        logic               american;
    } in_item_t;

    typedef struct packed {
        logic [31:0] price;
        logic        overflow;
    } out_item_t;

    // datapath commands
    typedef enum logic [3:0] {
        DP_NOP,
        DP_LOAD,
        DP_L_NODE,
        DP_L_DNM,
        DP_L_DNR,
        DP_L_UPM,
        DP_L_UPR,
        DP_F_START,
        DP_F_RDL,
        DP_F_RDU,
        DP_F_M1,
        DP_F_M2,
        DP_F_M3,
        DP_F_M4,
        DP_F_WR,
        DP_OUT
    } dp_op_t;

    // controller states
    typedef enum logic [3:0] {
        S_IDLE,
        S_L_NODE,
        S_L_DNM,
        S_L_DNR,
        S_L_UPM,
        S_L_UPR,
        S_F_START,
        S_F_RDL,
        S_F_RDU,
        S_F_M1,
        S_F_M2,
        S_F_M3,
        S_F_M4,
        S_F_WR,
        S_RD_ROOT,
        S_DONE
    } ctrl_state_t;

    // datapath status back to the controller
    typedef struct packed {
        logic n_zero;
        logic lvl_eq_n;
        logic k_eq_n;
        logic k_eq_lvl;
        logic lvl_zero;
    } dp_status_t;

    // exercise payoff, exact in Q16.16
    function automatic logic [31:0] payoff(input logic [31:0] s,
                                           input logic [31:0] k,
                                           input logic        put);
        logic [31:0] r;
        if (put)
            r = (s < k) ? (k - s) : 32'd0;
        else
            r = (s > k) ? (s - k) : 32'd0;
        return r;
    endfunction

endpackage

@@ sv/binomial_tree_option_pricer_top.sv @@
// The leaf fill and the backward fold share the 32x32 multiplier. One
// transaction is in flight at a time; the next is taken once the result is
// in the output register.
// Reset clears the sequencer and loads the configuration defaults; the node
// and exercise memories are not cleared.
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer_top
// CRR binomial tree pricer for European and American calls and puts.
// ----------------------------------------------------------------------------
module binomial_tree_option_pricer_top
    import btop_pkg::*;
#(
    parameter int MAX_STEPS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_ready,
    input  in_item_t             in_data,
    output logic                 out_valid,
    input  logic                 out_ready,
    output out_item_t            out_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data
);

    dp_op_t     op;
    dp_status_t status;

    // config writes always complete
    assign cfg_ready = 1'b1;

    btop_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .op        (op)
    );

    btop_dp #(.MAX_STEPS(MAX_STEPS)) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_valid & cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_data   (in_data),
        .op        (op),
        .status    (status),
        .out_data  (out_data)
    );

endmodule

@@ sv/btop_ram.sv @@
// ----------------------------------------------------------------------------
// btop_ram
// Generic single write port RAM with one registered read port.
// ----------------------------------------------------------------------------
module btop_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 257
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ sv/btop_ctrl.sv @@
// ----------------------------------------------------------------------------
// btop_ctrl
// Sequencer: leaf fill, backward fold and result hand-off.
// ----------------------------------------------------------------------------
module btop_ctrl
    import btop_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_ready,
    output logic       out_valid,
    input  logic       out_ready,
    input  dp_status_t status,
    output dp_op_t     op
);

    ctrl_state_t state_reg, state_next;
    logic        out_valid_reg, out_valid_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // next state and commands
    always_comb
    begin
        state_next     = state_reg;
        op             = DP_NOP;
        out_valid_next = out_valid_reg && !out_ready;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    op         = DP_LOAD;
                    state_next = S_L_NODE;
                end
            end
            S_L_NODE:
            begin
                op = DP_L_NODE;
                if (status.lvl_eq_n)
                begin
                    if (status.k_eq_n)
                        state_next = status.n_zero ? S_RD_ROOT : S_F_START;
                    else
                        state_next = S_L_UPM;
                end
                else
                begin
                    state_next = S_L_DNM;
                end
            end
            S_L_DNM:
            begin
                op         = DP_L_DNM;
                state_next = S_L_DNR;
            end
            S_L_DNR:
            begin
                op         = DP_L_DNR;
                state_next = S_L_NODE;
            end
            S_L_UPM:
            begin
                op         = DP_L_UPM;
                state_next = S_L_UPR;
            end
            S_L_UPR:
            begin
                op         = DP_L_UPR;
                state_next = S_L_NODE;
            end
            S_F_START:
            begin
                op         = DP_F_START;
                state_next = S_F_RDL;
            end
            S_F_RDL:
            begin
                op         = DP_F_RDL;
                state_next = S_F_RDU;
            end
            S_F_RDU:
            begin
                op         = DP_F_RDU;
                state_next = S_F_M1;
            end
            S_F_M1:
            begin
                op         = DP_F_M1;
                state_next = S_F_M2;
            end
            S_F_M2:
            begin
                op         = DP_F_M2;
                state_next = S_F_M3;
            end
            S_F_M3:
            begin
                op         = DP_F_M3;
                state_next = S_F_M4;
            end
            S_F_M4:
            begin
                op         = DP_F_M4;
                state_next = S_F_WR;
            end
            S_F_WR:
            begin
                op = DP_F_WR;
                if (status.k_eq_lvl && status.lvl_zero)
                    state_next = S_RD_ROOT;
                else
                    state_next = S_F_RDL;
            end
            S_RD_ROOT:
            begin
                // root was just written; re-read it before hand-off
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // load the output register once it is free
                if (!out_valid_reg || out_ready)
                begin
                    op             = DP_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

@@ sv/btop_dp.sv @@
// ----------------------------------------------------------------------------
// btop_dp
// Datapath: config registers, shared 32x32 multiplier, node and exercise RAMs.
// ----------------------------------------------------------------------------
module btop_dp
    import btop_pkg::*;
#(
    parameter int MAX_STEPS = 256
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [31:0]          cfg_data,
    input  in_item_t             in_data,
    input  dp_op_t               op,
    output dp_status_t           status,
    output out_item_t            out_data
);

    localparam int SW       = $clog2(MAX_STEPS + 1);
    localparam int EX_DEPTH = (MAX_STEPS + 1) * (MAX_STEPS + 1);
    localparam int EW       = $clog2(EX_DEPTH);

    // configuration registers
    logic [31:0] up_reg, down_reg, prob_reg, disc_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            up_reg   <= UP_FACTOR_RST;
            down_reg <= DOWN_FACTOR_RST;
            prob_reg <= UP_PROB_RST;
            disc_reg <= DISCOUNT_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_UP_FACTOR:   up_reg   <= cfg_data;
                REG_DOWN_FACTOR: down_reg <= cfg_data;
                REG_UP_PROB:     prob_reg <= cfg_data;
                REG_DISCOUNT:    disc_reg <= cfg_data;
                default:         ;
            endcase
        end
    end

    // clamped fold coefficients
    logic [31:0] q, qc, d;
    assign q  = (prob_reg > ONE_Q31) ? ONE_Q31 : prob_reg;
    assign qc = ONE_Q31 - q;
    assign d  = (disc_reg > ONE_Q31) ? ONE_Q31 : disc_reg;

    // transaction and working registers
    logic [31:0]   spot_reg, strike_reg;
    logic          put_reg, amer_reg, ovf_reg;
    logic [SW-1:0] n_reg, k_reg, lvl_reg;
    logic [31:0]   xu_reg, x_reg;
    logic [EW-1:0] exaddr_reg, exbase_reg;
    logic [63:0]   prod_reg, acc_reg;
    logic [31:0]   lower_reg, upper_reg, exv_reg, m_reg;
    out_item_t     out_reg;

    // memories
    logic          node_we, ex_we;
    logic [SW-1:0] node_waddr, node_raddr;
    logic [31:0]   node_wdata, node_rdata, ex_rdata;

    btop_ram #(.WIDTH(32), .DEPTH(MAX_STEPS + 1)) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    btop_ram #(.WIDTH(32), .DEPTH(EX_DEPTH)) u_ex_ram (
        .clk   (clk),
        .we    (ex_we),
        .waddr (exaddr_reg),
        .wdata (node_wdata),
        .raddr (exaddr_reg),
        .rdata (ex_rdata)
    );

    // shared multiplier operand select
    logic [31:0] mul_a, mul_b;
    always_comb
    begin
        mul_a = x_reg;
        mul_b = down_reg;
        case (op)
            DP_L_UPM:
            begin
                mul_a = xu_reg;
                mul_b = up_reg;
            end
            DP_F_M1:
            begin
                mul_a = qc;
                mul_b = lower_reg;
            end
            DP_F_M2:
            begin
                mul_a = q;
                mul_b = upper_reg;
            end
            DP_F_M4:
            begin
                mul_a = m_reg;
                mul_b = d;
            end
            default:
            begin
                mul_a = x_reg;
                mul_b = down_reg;
            end
        endcase
    end

    // Q2.30 round half up with saturation
    logic [64:0] rnd30;
    logic [34:0] r30;
    logic        sat;
    logic [31:0] sat_val;
    assign rnd30   = {1'b0, prod_reg} + 65'(1 << 29);
    assign r30     = rnd30[64:30];
    assign sat     = |r30[34:32];
    assign sat_val = sat ? 32'hFFFF_FFFF : r30[31:0];

    // fold arithmetic
    logic [64:0] fsum, cnt_sum;
    logic [31:0] cont, fin;
    assign fsum    = {1'b0, acc_reg} + {1'b0, prod_reg} + 65'(1 << 30);
    assign cnt_sum = {1'b0, prod_reg} + 65'(1 << 30);
    assign cont    = cnt_sum[62:31];
    assign fin     = (amer_reg && (exv_reg > cont)) ? exv_reg : cont;

    logic [31:0] pay_x;
    assign pay_x = payoff(x_reg, strike_reg, put_reg);

    // memory ports
    always_comb
    begin
        node_we    = 1'b0;
        ex_we      = 1'b0;
        node_waddr = k_reg;
        node_wdata = pay_x;
        node_raddr = k_reg;
        case (op)
            DP_L_NODE:
            begin
                ex_we   = 1'b1;
                node_we = (lvl_reg == n_reg);
            end
            DP_F_RDU:
            begin
                node_raddr = k_reg + SW'(1);
            end
            DP_F_WR:
            begin
                node_we    = 1'b1;
                node_wdata = fin;
            end
            default:
            begin
                node_we = 1'b0;
            end
        endcase
    end

    // steps clamp
    logic [SW-1:0] steps_c;
    assign steps_c = (32'(in_data.steps) > 32'(MAX_STEPS)) ? SW'(MAX_STEPS)
                                                            : SW'(in_data.steps);

    // working register updates
    always_ff @(posedge clk)
    begin
        case (op)
            DP_LOAD:
            begin
                spot_reg   <= in_data.spot;
                strike_reg <= in_data.strike;
                put_reg    <= in_data.is_put;
                amer_reg   <= in_data.american;
                n_reg      <= steps_c;
                k_reg      <= '0;
                lvl_reg    <= '0;
                xu_reg     <= in_data.spot;
                x_reg      <= in_data.spot;
                exaddr_reg <= '0;
                exbase_reg <= '0;
                ovf_reg    <= 1'b0;
            end
            DP_L_DNM, DP_L_UPM, DP_F_M1, DP_F_M4:
            begin
                prod_reg <= mul_a * mul_b;
                if (op == DP_L_UPM)
                    k_reg <= k_reg + SW'(1);
            end
            DP_L_DNR:
            begin
                x_reg      <= sat_val;
                ovf_reg    <= ovf_reg | sat;
                lvl_reg    <= lvl_reg + SW'(1);
                exaddr_reg <= exaddr_reg + EW'(1);
            end
            DP_L_UPR:
            begin
                xu_reg     <= sat_val;
                x_reg      <= sat_val;
                ovf_reg    <= ovf_reg | sat;
                lvl_reg    <= k_reg;
                exbase_reg <= exbase_reg + EW'(MAX_STEPS + 2);
                exaddr_reg <= exbase_reg + EW'(MAX_STEPS + 2);
            end
            DP_F_START:
            begin
                lvl_reg    <= n_reg - SW'(1);
                k_reg      <= '0;
                exaddr_reg <= EW'(n_reg - SW'(1));
            end
            DP_F_RDU:
            begin
                lower_reg <= node_rdata;
                exv_reg   <= ex_rdata;
            end
            DP_F_M2:
            begin
                acc_reg  <= prod_reg;
                prod_reg <= mul_a * mul_b;
            end
            DP_F_M3:
            begin
                m_reg <= fsum[62:31];
            end
            DP_F_WR:
            begin
                if (k_reg == lvl_reg)
                begin
                    lvl_reg    <= lvl_reg - SW'(1);
                    k_reg      <= '0;
                    exaddr_reg <= EW'(lvl_reg - SW'(1));
                end
                else
                begin
                    k_reg      <= k_reg + SW'(1);
                    exaddr_reg <= exaddr_reg + EW'(MAX_STEPS + 1);
                end
            end
            DP_OUT:
            begin
                out_reg.price    <= node_rdata;
                out_reg.overflow <= ovf_reg;
            end
            default:
            begin
            end
        endcase
        // upper value arrives in the cycle after its read
        if (op == DP_F_M1)
            upper_reg <= node_rdata;
    end

    // status
    assign status.n_zero   = (n_reg == '0);
    assign status.lvl_eq_n = (lvl_reg == n_reg);
    assign status.k_eq_n   = (k_reg == n_reg);
    assign status.k_eq_lvl = (k_reg == lvl_reg);
    assign status.lvl_zero = (lvl_reg == '0);

    assign out_data = out_reg;

endmodule

@@ verif/binomial_tree_option_pricer_top_tb.sv @@
// ----------------------------------------------------------------------------
// binomial_tree_option_pricer_top_tb
// Self-checking bench for the binomial tree pricer. Pricing requests go
// through a valid/ready driver, and each accepted request is priced by a
// local fixed-point tree fold. Results are compared in order against that
// prediction. The register settings change between phases, and both the
// request side and the result side stall in random bursts but in the last phase.
// ----------------------------------------------------------------------------
module binomial_tree_option_pricer_top_tb;
    import btop_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int TREE_MAX  = 256;
    localparam int WDOG_MAX  = 1500000;
    localparam int MAX_SHOWN = 10;
    // register indexes past the end of the map, which the block must ignore
    localparam logic [CFG_IDX_W-1:0] REG_NONE_LO = 8'd4;
    localparam logic [CFG_IDX_W-1:0] REG_NONE_HI = 8'd255;
    localparam logic [31:0] Q16_ONE = 32'h0001_0000;

    logic           clk;
    logic           rst_n;
    logic           in_valid;
    logic           in_ready;
    in_item_t       in_data;
    logic           out_valid;
    logic           out_ready;
    out_item_t      out_data;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [31:0]    cfg_data;

    // register copy kept by the bench
    logic [31:0] up_f;
    logic [31:0] dn_f;
    logic [31:0] q_prob;
    logic [31:0] disc;

    in_item_t  request_q[$];
    out_item_t price_q[$];
    int        mismatches;
    bit        quiet;
    int        wdog;

    binomial_tree_option_pricer_top #(.MAX_STEPS(TREE_MAX)) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 4 ns clock
    always
    begin
        clk = 1'b1;
        #2;
        clk = 1'b0;
        #2;
    end

    // Q2.30 multiply with round half up, saturating to 32 bits
    function automatic logic [31:0] q30_mul(input logic [31:0] x, input logic [31:0] f,
                                            inout bit sat);
        logic [63:0] r;
        r = ({32'd0, x} * {32'd0, f} + 64'h2000_0000) >> 30;
        if (r > 64'hFFFF_FFFF)
        begin
            sat = 1'b1;
            return 32'hFFFF_FFFF;
        end
        return r[31:0];
    endfunction

    function automatic logic [31:0] node_asset(input logic [31:0] s0, input int lvl,
                                               input int k, inout bit sat);
        logic [31:0] x;
        x = s0;
        for (int j = 0; j < k; j++)
            x = q30_mul(x, up_f, sat);
        for (int j = k; j < lvl; j++)
            x = q30_mul(x, dn_f, sat);
        return x;
    endfunction

    function automatic logic [31:0] exercise(input logic [31:0] s, input logic [31:0] k,
                                             input logic put);
        if (put)
            return (s < k) ? k - s : 32'd0;
        return (s > k) ? s - k : 32'd0;
    endfunction

    // root value of the tree for one request under the current registers
    function automatic out_item_t price_option(input in_item_t rq);
        logic [31:0] nodes[0:TREE_MAX];
        logic [63:0] q;
        logic [63:0] qc;
        logic [63:0] d;
        logic [63:0] s;
        logic [63:0] m;
        logic [31:0] cont;
        logic [31:0] ex;
        bit          sat;
        int          n_steps;
        out_item_t   res;
        sat = 1'b0;
        q = (q_prob > ONE_Q31) ? {32'd0, ONE_Q31} : {32'd0, q_prob};
        qc = {32'd0, ONE_Q31} - q;
        d = (disc > ONE_Q31) ? {32'd0, ONE_Q31} : {32'd0, disc};
        n_steps = (rq.steps > TREE_MAX) ? TREE_MAX : int'(rq.steps);
        for (int k = 0; k <= n_steps; k++)
            nodes[k] = exercise(node_asset(rq.spot, n_steps, k, sat), rq.strike, rq.is_put);
        for (int n = n_steps; n > 0; n--)
        begin
            for (int k = 0; k <= n - 1; k++)
            begin
                s = q * {32'd0, nodes[k+1]} + qc * {32'd0, nodes[k]};
                m = (s + 64'h4000_0000) >> 31;
                cont = 32'((m * d + 64'h4000_0000) >> 31);
                if (rq.american)
                begin
                    ex = exercise(node_asset(rq.spot, n - 1, k, sat), rq.strike, rq.is_put);
                    if (ex > cont)
                        cont = ex;
                end
                nodes[k] = cont;
            end
        end
        res.price = nodes[0];
        res.overflow = sat;
        return res;
    endfunction

    // request driver with random idle bursts
    int in_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
            in_data  <= '0;
            in_gap   <= 0;
        end
        else
        begin
            if (in_valid && in_ready)
                price_q.push_back(price_option(in_data));
            if (!in_valid || in_ready)
            begin
                if (in_gap > 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= in_gap - 1;
                end
                else if (request_q.size() > 0 && !quiet && $urandom_range(0, 5) == 0)
                begin
                    in_valid <= 1'b0;
                    in_gap   <= $urandom_range(1, 14) - 1;
                end
                else if (request_q.size() > 0)
                begin
                    in_valid <= 1'b1;
                    in_data  <= request_q.pop_front();
                end
                else
                    in_valid <= 1'b0;
            end
        end
    end

    // result monitor with random back-pressure bursts
    int out_gap;
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
            out_gap   <= 0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (price_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= MAX_SHOWN)
                        $display("unexpected result: price %h overflow %b",
                                 out_data.price, out_data.overflow);
                end
                else
                begin
                    out_item_t exp_r;
                    exp_r = price_q.pop_front();
                    if (exp_r.price !== out_data.price || exp_r.overflow !== out_data.overflow)
                    begin
                        mismatches++;
                        if (mismatches <= MAX_SHOWN)
                            $display("mismatch: price exp %h got %h, overflow exp %b got %b",
                                     exp_r.price, out_data.price,
                                     exp_r.overflow, out_data.overflow);
                    end
                end
            end
            if (out_gap > 0)
            begin
                out_ready <= 1'b0;
                out_gap   <= out_gap - 1;
            end
            else if (!quiet && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                out_gap   <= $urandom_range(1, 14) - 1;
            end
            else
                out_ready <= 1'b1;
        end
    end

    // watchdog on cycles without any transaction
    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready)
            || (cfg_valid && cfg_ready))
            wdog <= 0;
        else if (wdog >= WDOG_MAX)
        begin
            $display("binomial_tree_option_pricer_top_tb: FAIL");
            $finish;
        end
        else
            wdog <= wdog + 1;
    end

    task automatic add_request(input logic [31:0] spot, input logic [31:0] strike,
                               input logic [8:0] steps, input logic put, input logic amer);
        in_item_t rq;
        rq.spot = spot;
        rq.strike = strike;
        rq.steps = steps;
        rq.is_put = put;
        rq.american = amer;
        request_q.push_back(rq);
    endtask

    // config write, only called while the block is idle
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        case (idx)
            REG_UP_FACTOR:   up_f = val;
            REG_DOWN_FACTOR: dn_f = val;
            REG_UP_PROB:     q_prob = val;
            REG_DISCOUNT:    disc = val;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    task automatic wait_drained();
        while (request_q.size() > 0 || in_valid || price_q.size() > 0)
            @(posedge clk);
    endtask

    task automatic random_request();
        logic [31:0] sp;
        logic [31:0] kx;
        logic [8:0]  st;
        if ($urandom_range(0, 7) == 0)
        begin
            sp = $urandom;
            kx = $urandom;
        end
        else
        begin
            sp = ($urandom_range(50, 200) << 16) | $urandom_range(0, 16'hFFFF);
            kx = ($urandom_range(50, 200) << 16) | $urandom_range(0, 16'hFFFF);
        end
        st = ($urandom_range(0, 9) == 0) ? 9'($urandom_range(13, 40))
                                          : 9'($urandom_range(0, 12));
        add_request(sp, kx, st, 1'($urandom), 1'($urandom));
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = '0;
        cfg_data = '0;
        mismatches = 0;
        quiet = 1'b0;
        wdog = 0;
        up_f = UP_FACTOR_RST;
        dn_f = DOWN_FACTOR_RST;
        q_prob = UP_PROB_RST;
        disc = DISCOUNT_RST;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // reset settings: every option kind, zero and clamped step counts
        for (int k = 0; k < 4; k++)
        begin
            add_request(100 * Q16_ONE, 100 * Q16_ONE, 9'd3, k[0], k[1]);
            add_request(100 * Q16_ONE, 95 * Q16_ONE, 9'd1, k[0], k[1]);
        end
        add_request(100 * Q16_ONE, 90 * Q16_ONE, 9'd0, 1'b0, 1'b0);
        add_request(100 * Q16_ONE, 90 * Q16_ONE, 9'd0, 1'b1, 1'b1);
        add_request(32'd0, 32'hFFFF_FFFF, 9'd2, 1'b1, 1'b1);
        add_request(32'hFFFF_FFFF, 32'd0, 9'd4, 1'b0, 1'b1);
        add_request(100 * Q16_ONE, 110 * Q16_ONE, 9'h1FF, 1'b1, 1'b1);
        wait_drained();

        // extreme settings, incl. clamped probability/discount, ignored indexes
        write_reg(REG_UP_FACTOR, 32'hFFFF_FFFF);
        write_reg(REG_DOWN_FACTOR, 32'd0);
        write_reg(REG_UP_PROB, 32'hFFFF_FFFF);
        write_reg(REG_DISCOUNT, 32'hFFFF_FFFF);
        write_reg(REG_NONE_LO, 32'h1234_5678);
        write_reg(REG_NONE_HI, 32'd0);
        add_request(32'hFFFF_FFFF, 32'd1, 9'd3, 1'b0, 1'b0);
        add_request(32'h4000_0000, 32'h8000_0000, 9'd5, 1'b1, 1'b1);
        add_request(100 * Q16_ONE, 100 * Q16_ONE, 9'd6, 1'b0, 1'b1);
        wait_drained();

        write_reg(REG_UP_FACTOR, 32'd0);
        write_reg(REG_DOWN_FACTOR, 32'hFFFF_FFFF);
        write_reg(REG_UP_PROB, 32'd0);
        write_reg(REG_DISCOUNT, 32'd0);
        add_request(32'hFFFF_FFFF, 32'd7, 9'd4, 1'b0, 1'b1);
        add_request(100 * Q16_ONE, 100 * Q16_ONE, 9'd5, 1'b1, 1'b0);
        add_request(100 * Q16_ONE, 100 * Q16_ONE, 9'd5, 1'b1, 1'b1);
        wait_drained();

        // random phases, the last without idling
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_UP_FACTOR, (32'd1 << 30) + $urandom_range(0, 32'h1333_3333));
            write_reg(REG_DOWN_FACTOR, (32'd1 << 30) - $urandom_range(0, 32'h1333_3333));
            write_reg(REG_UP_PROB, ($urandom_range(0, 4) == 0) ? $urandom
                                                                : $urandom_range(0, ONE_Q31));
            write_reg(REG_DISCOUNT, ($urandom_range(0, 4) == 0) ? $urandom
                                    : $urandom_range(32'h7000_0000, ONE_Q31));
            if (ph == 3)
                quiet = 1'b1;
            repeat (22) random_request();
            wait_drained();
        end

        repeat (50) @(posedge clk);
        if (mismatches == 0 && price_q.size() == 0)
            $display("binomial_tree_option_pricer_top_tb: PASS");
        else
            $display("binomial_tree_option_pricer_top_tb: FAIL");
        $finish;
    end

endmodule
